### rtl/bleadv_pkg.sv
// Package with the codes, widths and result type of the advertising data parser.
package bleadv_pkg;

    // Command codes carried on the input tuser
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Result kinds carried on the output tuser
    localparam logic [1:0] KIND_NAME_START = 2'd0;
    localparam logic [1:0] KIND_NAME_BYTE  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY    = 2'd2;

    // Parser phases
    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Element handling modes
    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_NAME   = 2'd1;
    localparam logic [1:0] MODE_POWER  = 2'd2;

    // Advertising data element types
    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;
    localparam logic [7:0] AD_TX_POWER      = 8'h0A;

    // Stream widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // One result item
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        name_byte;
        logic signed [7:0] pwr_dbm;
        logic              pwr_valid;
        logic              has_name;
        logic              last;
    } result_t;

endpackage

### rtl/ble_adv_data_field_parser_core.sv
// Top level: length/type/value walker over BLE advertising data, one byte per request.
//
// The block takes one request per clock cycle unless the result register is
// held, and gives at most one result per request from the result register. The
// rate is set by the single pass of counter and compare logic between the input
// and result registers, which also updates the parser state,
// so requests may follow back to back. A begin request loads the report
// length and clears all report state; data requests step the parser through
// elements; an end request emits a summary with tlast set. Name elements emit a
// restart marker (kind 0) and then one result per name byte (kind 1). When the
// result register is held by the downstream side, the input register holds too.
module ble_adv_data_field_parser_core
    import bleadv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] data_length, [15:8] data_byte
    input  logic [1:0]          s_tuser,   // [1:0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] name_byte, [15:8] power in dBm,
                                           // [16] power valid, [17] has_name, zero above
    output logic [1:0]          m_tuser,   // [1:0] kind
    output logic                m_tlast    // last
);

    // Input register
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_len_reg;
    logic [7:0] in_byte_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_reg;

    // Parser state
    logic [1:0] phase_reg, phase_next;
    logic [7:0] report_left_reg, report_left_next;
    logic [7:0] value_left_reg, value_left_next;
    logic [1:0] mode_reg, mode_next;
    logic       name_held_reg, name_held_next;
    logic [7:0] power_value_reg, power_value_next;
    logic       power_present_reg, power_present_next;

    logic       advance;
    logic       res_valid;
    result_t    res;
    logic [7:0] value_dec;

    // Move the input request on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign value_dec = (value_left_reg != 8'd0) ? (value_left_reg - 8'd1) : 8'd0;

    // Step the parser for the request in the input register
    always_comb
    begin
        phase_next         = phase_reg;
        report_left_next   = report_left_reg;
        value_left_next    = value_left_reg;
        mode_next          = mode_reg;
        name_held_next     = name_held_reg;
        power_value_next   = power_value_reg;
        power_present_next = power_present_reg;
        res_valid          = 1'b0;
        res                = '0;

        case (in_cmd_reg)
            CMD_BEGIN:
            begin
                phase_next         = PH_LEN;
                report_left_next   = in_len_reg;
                value_left_next    = 8'd0;
                mode_next          = MODE_IGNORE;
                name_held_next     = 1'b0;
                power_value_next   = 8'd0;
                power_present_next = 1'b0;
            end
            CMD_END:
            begin
                res_valid     = 1'b1;
                res.kind      = KIND_SUMMARY;
                res.pwr_dbm   = power_present_reg ? power_value_reg : 8'd0;
                res.pwr_valid = power_present_reg;
                res.has_name  = name_held_reg;
                res.last      = 1'b1;
                phase_next    = PH_STOP;
            end
            CMD_DATA:
            begin
                if (phase_reg != PH_STOP && report_left_reg != 8'd0)
                begin
                    case (phase_reg)
                        PH_LEN:
                        begin
                            // Stop on an empty element or one that runs past the report
                            if (in_byte_reg == 8'd0 || in_byte_reg >= report_left_reg)
                            begin
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                value_left_next  = in_byte_reg - 8'd1;
                                report_left_next = report_left_reg - 8'd1;
                                phase_next       = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            report_left_next = report_left_reg - 8'd1;
                            mode_next        = MODE_IGNORE;
                            if (in_byte_reg == AD_NAME_COMPLETE ||
                                (in_byte_reg == AD_NAME_SHORT && !name_held_reg))
                            begin
                                mode_next      = MODE_NAME;
                                name_held_next = (value_left_reg != 8'd0);
                                res_valid      = 1'b1;
                                res.kind       = KIND_NAME_START;
                            end
                            else if (in_byte_reg == AD_TX_POWER && value_left_reg == 8'd1)
                            begin
                                mode_next = MODE_POWER;
                            end
                            phase_next = (value_left_reg == 8'd0) ? PH_LEN : PH_VALUE;
                        end
                        PH_VALUE:
                        begin
                            report_left_next = report_left_reg - 8'd1;
                            value_left_next  = value_dec;
                            if (mode_reg == MODE_NAME)
                            begin
                                res_valid     = 1'b1;
                                res.kind      = KIND_NAME_BYTE;
                                res.name_byte = in_byte_reg;
                            end
                            else if (mode_reg == MODE_POWER)
                            begin
                                power_value_next   = in_byte_reg;
                                power_present_next = 1'b1;
                            end
                            if (value_dec == 8'd0)
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_STOP;
                        end
                    endcase
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Capture input requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_len_reg  <= s_tdata[7:0];
            in_byte_reg <= s_tdata[15:8];
        end
    end

    // Update parser state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN;
            report_left_reg   <= 8'd0;
            value_left_reg    <= 8'd0;
            mode_reg          <= MODE_IGNORE;
            name_held_reg     <= 1'b0;
            power_value_reg   <= 8'd0;
            power_present_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg         <= phase_next;
                report_left_reg   <= report_left_next;
                value_left_reg    <= value_left_next;
                mode_reg          <= mode_next;
                name_held_reg     <= name_held_next;
                power_value_reg   <= power_value_next;
                power_present_reg <= power_present_next;
                out_valid_reg     <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Drive the output stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'd0, out_reg.has_name, out_reg.pwr_valid,
                       out_reg.pwr_dbm, out_reg.name_byte};

    // Check internal consistency
    a_last_on_summary : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
        else $error("tlast does not match summary kind");

    a_name_fields_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_SUMMARY) |-> (m_tdata[17:8] == 10'd0))
        else $error("name result carries summary fields");

    a_value_count : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |-> (value_left_reg != 8'd0))
        else $error("value phase with no value bytes left");

    a_power_clear : assert property (@(posedge clk) disable iff (!rst_n)
        !power_present_reg |-> (power_value_reg == 8'd0))
        else $error("power value set without power present");

endmodule

### tb/tb.sv
// Testbench for the advertising data parser: directed and random reports checked against a predictor.
module tb;
    import bleadv_pkg::*;

    // Command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // [7:0] data_length, [15:8] data_byte
    logic [1:0]          s_tuser = CMD_BEGIN;   // [1:0] command
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // [7:0] name_byte, [15:8] power in dBm,
                                    // [16] power valid, [17] has_name, zero above
    logic [1:0]          m_tuser;   // [1:0] kind
    logic                m_tlast;   // last

    // Predicted parser state
    logic [1:0] ps_phase;
    logic [7:0] ps_report_left;
    logic [7:0] ps_value_left;
    logic [1:0] ps_mode;
    logic       ps_name_held;
    logic [7:0] ps_power;
    logic       ps_power_seen;

    result_t parser_results_due[$];
    int      mismatches = 0;
    int      requests_sent = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;

    ble_adv_data_field_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Clear all report state, as a begin request or reset does
    task automatic clear_parser_state();
        ps_phase       = PH_LEN;
        ps_report_left = 8'd0;
        ps_value_left  = 8'd0;
        ps_mode        = MODE_IGNORE;
        ps_name_held   = 1'b0;
        ps_power       = 8'd0;
        ps_power_seen  = 1'b0;
    endtask

    // Step the predicted parser by one accepted request; queue any result
    task automatic advance_parser(input logic [1:0] cmd, input logic [7:0] len,
                                  input logic [7:0] dbyte);
        result_t r;
        r = '0;
        if (cmd == CMD_BEGIN)
        begin
            clear_parser_state();
            ps_report_left = len;
        end
        else if (cmd == CMD_END)
        begin
            r.kind      = KIND_SUMMARY;
            r.pwr_dbm   = ps_power_seen ? ps_power : 8'd0;
            r.pwr_valid = ps_power_seen;
            r.has_name  = ps_name_held;
            r.last      = 1'b1;
            parser_results_due.push_back(r);
            ps_phase = PH_STOP;
        end
        else if (cmd == CMD_DATA && ps_phase != PH_STOP && ps_report_left != 8'd0)
        begin
            if (ps_phase == PH_LEN)
            begin
                // a zero length or an element running past the report stops parsing
                if (dbyte == 8'd0 || int'(dbyte) + 1 > int'(ps_report_left))
                    ps_phase = PH_STOP;
                else
                begin
                    ps_value_left  = dbyte - 8'd1;
                    ps_report_left = ps_report_left - 8'd1;
                    ps_phase       = PH_TYPE;
                end
            end
            else if (ps_phase == PH_TYPE)
            begin
                ps_report_left = ps_report_left - 8'd1;
                ps_mode        = MODE_IGNORE;
                if (dbyte == AD_NAME_COMPLETE || (dbyte == AD_NAME_SHORT && !ps_name_held))
                begin
                    ps_mode      = MODE_NAME;
                    ps_name_held = (ps_value_left != 8'd0);
                    r.kind       = KIND_NAME_START;
                    parser_results_due.push_back(r);
                end
                else if (dbyte == AD_TX_POWER && ps_value_left == 8'd1)
                    ps_mode = MODE_POWER;
                ps_phase = (ps_value_left == 8'd0) ? PH_LEN : PH_VALUE;
            end
            else
            begin
                ps_report_left = ps_report_left - 8'd1;
                if (ps_value_left != 8'd0)
                    ps_value_left = ps_value_left - 8'd1;
                if (ps_mode == MODE_NAME)
                begin
                    r.kind      = KIND_NAME_BYTE;
                    r.name_byte = dbyte;
                    parser_results_due.push_back(r);
                end
                else if (ps_mode == MODE_POWER)
                begin
                    ps_power      = dbyte;
                    ps_power_seen = 1'b1;
                end
                if (ps_value_left == 8'd0)
                    ps_phase = PH_LEN;
            end
        end
    endtask

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] len,
                                input logic [7:0] dbyte);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dbyte, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_parser(cmd, len, dbyte);
        requests_sent++;
    endtask

    // Stop sending until every predicted result has come out
    task automatic hold_until_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (parser_results_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_end_without_begin();
        send_request(CMD_END, 8'h00, 8'h00);
    endtask

    // Complete name, negative power, then an empty complete name drops the held name
    task automatic test_name_and_power();
        send_request(CMD_BEGIN, 8'd9, 8'hFF);
        send_request(CMD_DATA, 8'hAA, 8'd3);
        send_request(CMD_DATA, 8'h55, AD_NAME_COMPLETE);
        send_request(CMD_DATA, 8'h00, 8'h41);
        send_request(CMD_DATA, 8'hFF, 8'hC2);
        send_request(CMD_DATA, 8'h00, 8'd2);
        send_request(CMD_DATA, 8'h00, AD_TX_POWER);
        send_request(CMD_DATA, 8'h00, 8'h80);
        send_request(CMD_DATA, 8'h00, 8'd1);
        send_request(CMD_DATA, 8'h00, AD_NAME_COMPLETE);
        send_request(CMD_END, 8'h00, 8'h00);
    endtask

    // Zero element length stops parsing; unknown command is dropped
    task automatic test_zero_length();
        send_request(CMD_BEGIN, 8'd255, 8'h00);
        send_request(CMD_DATA, 8'h00, 8'h00);
        send_request(CMD_DATA, 8'h00, 8'hFF);
        send_request(CMD_UNUSED, 8'hFF, 8'hFF);
        send_request(CMD_END, 8'h00, 8'h00);
    endtask

    // Power element of wrong length, element past the total, data after end
    task automatic test_overrun_and_late_data();
        send_request(CMD_BEGIN, 8'd4, 8'h00);
        send_request(CMD_DATA, 8'h00, 8'd1);
        send_request(CMD_DATA, 8'h00, AD_TX_POWER);
        send_request(CMD_DATA, 8'h00, 8'd2);
        send_request(CMD_DATA, 8'h00, AD_NAME_SHORT);
        send_request(CMD_END, 8'h00, 8'h00);
        send_request(CMD_DATA, 8'h00, 8'd1);
    endtask

    // Mostly well-formed reports with random content, some broken, some noise
    task automatic test_random_reports(input int target);
        logic [7:0] ad_bytes[$];
        int         n_elem;
        int         vlen;
        int         r;
        int         total;
        int         extra;
        int         drains;
        logic [7:0] etype;
        drains = 0;
        while (requests_sent < target)
        begin
            tx_steady = ($urandom_range(0, 9) == 0);
            rx_steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 12)
            begin
                // noise: any command with any fields
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
            end
            else
            begin
                ad_bytes.delete();
                n_elem = $urandom_range(0, 5);
                for (int e = 0; e < n_elem; e++)
                begin
                    r = $urandom_range(0, 99);
                    if (r >= 90)
                    begin
                        ad_bytes.push_back(8'd0);
                        break;
                    end
                    vlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 30)
                                                        : $urandom_range(0, 10);
                    if (r < 20)
                        etype = AD_NAME_SHORT;
                    else if (r < 35)
                        etype = AD_NAME_COMPLETE;
                    else if (r < 55)
                    begin
                        etype = AD_TX_POWER;
                        vlen  = 1;
                    end
                    else if (r < 65)
                    begin
                        etype = AD_TX_POWER;
                        vlen  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 3);
                    end
                    else
                        etype = 8'($urandom_range(0, 255));
                    ad_bytes.push_back(8'(vlen + 1));
                    ad_bytes.push_back(etype);
                    repeat (vlen)
                        ad_bytes.push_back(8'($urandom_range(0, 255)));
                end
                // total: mostly exact, sometimes short or long
                total = ad_bytes.size();
                r = $urandom_range(0, 99);
                if (r < 10)
                    total = $urandom_range(0, total);
                else if (r < 20)
                    total = total + $urandom_range(1, 40);
                else if (r < 23)
                    total = 255;
                if (total > 255)
                    total = 255;
                send_request(CMD_BEGIN, 8'(total), 8'($urandom_range(0, 255)));
                foreach (ad_bytes[i])
                    send_request(CMD_DATA, 8'($urandom_range(0, 255)), ad_bytes[i]);
                extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
                repeat (extra)
                    send_request(CMD_DATA, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) != 0)
                    send_request(CMD_END, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
            end
            if (drains < 3 && $urandom_range(0, 99) == 0)
            begin
                hold_until_drained();
                drains++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Downstream ready with random stalls
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap(rx_steady);
            end
        end
    end

    task automatic note_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parser_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0h tdata %0h", m_tuser, m_tdata);
            end
            else
            begin
                want = parser_results_due.pop_front();
                note_field("kind", 24'(want.kind), 24'(m_tuser));
                note_field("name_byte", 24'(want.name_byte), 24'(m_tdata[7:0]));
                note_field("power", 24'($unsigned(want.pwr_dbm)), 24'(m_tdata[15:8]));
                note_field("power valid", 24'(want.pwr_valid), 24'(m_tdata[16]));
                note_field("has_name", 24'(want.has_name), 24'(m_tdata[17]));
                note_field("tdata padding", 24'd0, 24'(m_tdata[23:18]));
                note_field("last", 24'(want.last), 24'(m_tlast));
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clear_parser_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_end_without_begin();
        hold_until_drained();
        test_name_and_power();
        hold_until_drained();
        test_zero_length();
        test_overrun_and_late_data();
        hold_until_drained();
        test_random_reports(1700);

        hold_until_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && parser_results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
